[hw/rtl/joystick_axis_average_framer_macros.svh]
// Assertion macros for the joystick axis averaging framer.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef JOYSTICK_AXIS_AVERAGE_FRAMER_MACROS_SVH
`define JOYSTICK_AXIS_AVERAGE_FRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define JAAF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define JAAF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define JAAF_ASSERT_IMP(label, ante, cons, msg)
`define JAAF_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

[hw/rtl/jaaf_pkg.sv]
// Shared types and constants for the joystick axis averaging framer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jaaf_pkg;
    localparam int SAMPLE_W   = 12;
    localparam int VAL_W      = 9;   // mapped value and average, two's complement
    localparam int BYTE_W     = 8;
    localparam int SPAN_W     = 9;
    localparam int PROD_W     = SAMPLE_W + SPAN_W;
    localparam int MAP_SPAN   = 510;
    localparam int MAP_FULL   = 4095;
    localparam int MAP_OFFSET = 255;
    localparam logic [BYTE_W-1:0] END_MARK = 8'hFF;

    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // frame beats
    localparam logic [1:0] BEAT_AXIS = 2'd0;
    localparam logic [1:0] BEAT_LOW  = 2'd1;
    localparam logic [1:0] BEAT_HIGH = 2'd2;
    localparam logic [1:0] BEAT_END  = 2'd3;

    typedef struct packed {
        logic                axis;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic             axis;
        logic [VAL_W-1:0] avg;
    } t_qentry;

    typedef struct packed {
        logic    valid;
        t_qentry entry;
    } t_qslot;
endpackage

`default_nettype wire

[hw/rtl/jaaf_front.sv]
// Front end: request intake, sample mapping, per-axis window and averaging.
// Depends on jaaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jaaf_front #(
    parameter int WINDOW = 5,
    parameter int AXES   = 2
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  wire jaaf_pkg::t_in_item i_item,
    output logic                    o_stall,
    output jaaf_pkg::t_qslot        o_push,
    input  wire                     i_pop
);
    import jaaf_pkg::*;

    localparam int SUM_MAX = WINDOW * MAP_OFFSET;
    localparam int MAG_W   = $clog2(SUM_MAX + 1);
    localparam int SUM_W   = MAG_W + 1;
    // exact divide by WINDOW for magnitudes below 2**MAG_W
    localparam int DIV_SH  = MAG_W + $clog2(WINDOW);
    localparam int RCP     = ((1 << DIV_SH) + WINDOW - 1) / WINDOW;
    localparam int RCP_W   = MAG_W + 1;
    localparam int DPROD_W = MAG_W + RCP_W;
    localparam int AVG_W   = VAL_W - 1;

    logic              acc_ok;
    logic [QCNT_W-1:0] r_credit;
    logic [QCNT_W-1:0] n_credit;

    logic                r_s1_valid;
    logic                r_s1_axis;
    logic [SAMPLE_W-1:0] r_s1_sample;

    logic              r_s2_valid;
    logic              r_s2_axis;
    logic [PROD_W-1:0] r_s2_prod;

    logic [SPAN_W-1:0]   s3_q0;
    logic [SAMPLE_W:0]   s3_rem;
    logic [SPAN_W-1:0]   s3_q;
    logic [VAL_W:0]      s3_wide;
    logic                r_s3_valid;
    logic                r_s3_axis;
    logic [VAL_W-1:0]    r_s3_val;

    logic [VAL_W-1:0] r_hist [AXES][WINDOW];
    logic [SUM_W-1:0] r_sum  [AXES];
    logic [SUM_W-1:0] s4_old_sum;
    logic [VAL_W-1:0] s4_oldest;
    logic [SUM_W-1:0] n_sum;
    logic             r_s4_valid;
    logic             r_s4_axis;
    logic [SUM_W-1:0] r_s4_sum;

    logic               s5_neg;
    logic [SUM_W-1:0]   s5_neg_sum;
    logic [MAG_W-1:0]   s5_mag;
    logic               r_s5_valid;
    logic               r_s5_axis;
    logic               r_s5_neg;
    logic [DPROD_W-1:0] r_s5_prod;

    logic [AVG_W-1:0] s6_q;
    logic [VAL_W-1:0] s6_pos;

    // out-of-range axes are taken and dropped; credits cover pipe plus queue
    assign o_stall  = (r_credit == QCNT_W'(QDEPTH));
    assign acc_ok   = i_valid && !o_stall && (32'(i_item.axis) < 32'(AXES));
    assign n_credit = r_credit + QCNT_W'(acc_ok) - QCNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit   <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            r_credit   <= n_credit;
            r_s1_valid <= acc_ok;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    // map: floor(sample*510/4095) - 255, divide by 4095 as 4096-1
    assign s3_q0   = r_s2_prod[PROD_W-1:SAMPLE_W];
    assign s3_rem  = {1'b0, r_s2_prod[SAMPLE_W-1:0]} + (SAMPLE_W+1)'(s3_q0);
    assign s3_q    = s3_q0 + SPAN_W'(s3_rem >= (SAMPLE_W+1)'(MAP_FULL));
    assign s3_wide = {1'b0, s3_q} - (VAL_W+1)'(MAP_OFFSET);

    always_comb begin
        s4_old_sum = '0;
        s4_oldest  = '0;
        for (int a = 0; a < AXES; a++) begin
            if (32'(r_s3_axis) == 32'(a)) begin
                s4_old_sum = r_sum[a];
                s4_oldest  = r_hist[a][0];
            end
        end
        n_sum = s4_old_sum
              - {{(SUM_W-VAL_W){s4_oldest[VAL_W-1]}}, s4_oldest}
              + {{(SUM_W-VAL_W){r_s3_val[VAL_W-1]}}, r_s3_val};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
                for (int w = 0; w < WINDOW; w++) begin
                    r_hist[a][w] <= '0;
                end
            end
        end else if (r_s3_valid) begin
            for (int a = 0; a < AXES; a++) begin
                if (32'(r_s3_axis) == 32'(a)) begin
                    for (int w = 0; w < WINDOW - 1; w++) begin
                        r_hist[a][w] <= r_hist[a][w+1];
                    end
                    r_hist[a][WINDOW-1] <= r_s3_val;
                    r_sum[a]            <= n_sum;
                end
            end
        end
    end

    // truncate toward zero: divide the magnitude, restore the sign
    assign s5_neg     = r_s4_sum[SUM_W-1];
    assign s5_neg_sum = -r_s4_sum;
    assign s5_mag     = s5_neg ? s5_neg_sum[MAG_W-1:0] : r_s4_sum[MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        r_s1_axis   <= i_item.axis;
        r_s1_sample <= i_item.sample;
        r_s2_axis   <= r_s1_axis;
        r_s2_prod   <= PROD_W'(r_s1_sample) * PROD_W'(MAP_SPAN);
        r_s3_axis   <= r_s2_axis;
        r_s3_val    <= s3_wide[VAL_W-1:0];
        r_s4_axis   <= r_s3_axis;
        r_s4_sum    <= n_sum;
        r_s5_axis   <= r_s4_axis;
        r_s5_neg    <= s5_neg;
        r_s5_prod   <= DPROD_W'(s5_mag) * DPROD_W'(RCP);
    end

    assign s6_q   = r_s5_prod[DIV_SH +: AVG_W];
    assign s6_pos = {1'b0, s6_q};

    assign o_push.valid      = r_s5_valid;
    assign o_push.entry.axis = r_s5_axis;
    assign o_push.entry.avg  = r_s5_neg ? -s6_pos : s6_pos;
endmodule

`default_nettype wire

[hw/rtl/jaaf_queue.sv]
// Short queue of averaged requests between the front end and the framer.
// Depends on jaaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jaaf_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire jaaf_pkg::t_qslot i_push,
    output jaaf_pkg::t_qslot      o_head,
    input  wire                   i_pop
);
    import jaaf_pkg::*;

    t_qentry           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    // front end holds credits, so a push never meets a full queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push.valid) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];
endmodule

`default_nettype wire

[hw/rtl/jaaf_back.sv]
// Back end: turns one queued average into a four-byte frame on the output.
// Depends on jaaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jaaf_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire jaaf_pkg::t_qslot i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    output jaaf_pkg::t_out_item   o_item,
    input  wire                   i_stall
);
    import jaaf_pkg::*;

    logic              r_fr_valid;
    t_qentry           r_fr;
    logic [1:0]        r_beat;
    logic              r_out_valid;
    t_out_item         r_out;
    logic              out_adv;
    logic              fr_done;
    logic [BYTE_W-1:0] beat_byte;

    assign out_adv = !r_out_valid || !i_stall;
    assign fr_done = r_fr_valid && out_adv && (r_beat == BEAT_END);
    // next frame loads in the cycle the end marker goes out
    assign o_pop   = i_head.valid && (!r_fr_valid || fr_done);

    always_comb begin
        case (r_beat)
            BEAT_AXIS: beat_byte = {{(BYTE_W-1){1'b0}}, r_fr.axis};
            BEAT_LOW:  beat_byte = r_fr.avg[BYTE_W-1:0];
            BEAT_HIGH: beat_byte = {BYTE_W{r_fr.avg[VAL_W-1]}};
            BEAT_END:  beat_byte = END_MARK;
            default:   beat_byte = END_MARK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fr_valid  <= 1'b0;
            r_beat      <= BEAT_AXIS;
            r_out_valid <= 1'b0;
        end else begin
            if (out_adv) begin
                r_out_valid <= r_fr_valid;
            end
            if (o_pop) begin
                r_fr_valid <= 1'b1;
                r_beat     <= BEAT_AXIS;
            end else if (fr_done) begin
                r_fr_valid <= 1'b0;
            end else if (r_fr_valid && out_adv) begin
                r_beat <= r_beat + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_out.frame_byte <= beat_byte;
            r_out.last       <= (r_beat == BEAT_END);
        end
        if (o_pop) begin
            r_fr <= i_head.entry;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;
endmodule

`default_nettype wire

[hw/rtl/joystick_axis_average_framer.sv]
// Joystick axis averaging framer top level: front end, queue, frame serializer.
// Depends on jaaf_pkg, jaaf_front, jaaf_queue, jaaf_back and joystick_axis_average_framer_macros.svh.
// A sample passes the front-end pipeline into the queue, then the frame register and
// the output register. Each queued sample leaves as four output bytes, which bound
// the sustained sample rate; intake stalls once 8 samples sit in front and queue.
// Reset (synchronous, active low) clears the axis history to zero and drops all frames.
`timescale 1ns / 1ps
`default_nettype none
`include "joystick_axis_average_framer_macros.svh"

module joystick_axis_average_framer #(
    parameter int WINDOW = 5,
    parameter int AXES   = 2
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  wire jaaf_pkg::t_in_item i_item,
    output logic                    o_stall,
    output logic                    o_valid,
    output jaaf_pkg::t_out_item     o_item,
    input  wire                     i_stall
);
    import jaaf_pkg::*;

    t_qslot w_push;
    t_qslot w_head;
    logic   w_pop;

    jaaf_front #(
        .WINDOW (WINDOW),
        .AXES   (AXES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_push  (w_push),
        .i_pop   (w_pop)
    );

    jaaf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    jaaf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (i_stall)
    );

    `JAAF_ASSERT_IMP(a_pop_has_head, w_pop, w_head.valid, "pop from empty queue")
    `JAAF_ASSERT_NXT(a_head_holds, w_head.valid && !w_pop, w_head.valid, "queued request lost")
    `JAAF_ASSERT_IMP(a_last_is_end, o_valid && o_item.last, o_item.frame_byte == END_MARK,
        "last beat without end marker")
endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking bench for joystick_axis_average_framer: random and directed samples
// with per-axis average prediction, checking every byte of each frame.
// Depends on jaaf_pkg and the framer RTL.
`timescale 1ns / 1ps

module testbench;
    import jaaf_pkg::*;

    localparam int WINDOW      = 5;
    localparam int AXES        = 2;
    localparam int N_DIRECTED  = 20;
    localparam int N_RANDOM    = 190;
    localparam int N_SAMPLES   = N_DIRECTED + N_RANDOM;
    localparam int HOLD_CYCLES = 250;

    typedef struct packed {
        t_in_item   item;
        logic [2:0] gap;     // idle cycles before offering this request
        logic       drain;   // hold this request until all frames are out
    } t_sample_req;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_item  i_item = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_item;

    joystick_axis_average_framer #(
        .WINDOW(WINDOW),
        .AXES  (AXES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_item (i_item),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_item (o_item),
        .i_stall(i_stall)
    );

    always #10 i_clk = ~i_clk;

    t_sample_req sample_reqs[$];
    t_out_item   frame_bytes_due[$];
    int          axis_hist[AXES][WINDOW];
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    int          n_neg_avg = 0;
    int          hold_cnt = 0;
    bit          hold_done = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;

    // shift the sample into its axis window and queue the four frame bytes
    function automatic void predict_frame(input t_in_item it);
        int        ax;
        int        mapped;
        int        sum;
        int        avg;
        t_out_item b;
        ax     = int'(it.axis);
        mapped = (int'(it.sample) * MAP_SPAN) / MAP_FULL - MAP_OFFSET;
        for (int k = 0; k < WINDOW - 1; k++)
            axis_hist[ax][k] = axis_hist[ax][k + 1];
        axis_hist[ax][WINDOW - 1] = mapped;
        sum = 0;
        for (int k = 0; k < WINDOW; k++)
            sum += axis_hist[ax][k];
        avg = sum / WINDOW;   // signed int division truncates toward zero
        if (avg < 0)
            n_neg_avg++;
        b.frame_byte = {{(BYTE_W-1){1'b0}}, it.axis};
        b.last       = 1'b0;
        frame_bytes_due.push_back(b);
        b.frame_byte = avg[7:0];
        frame_bytes_due.push_back(b);
        b.frame_byte = avg[15:8];  // sign bits for a negative average
        frame_bytes_due.push_back(b);
        b.frame_byte = END_MARK;
        b.last       = 1'b1;
        frame_bytes_due.push_back(b);
    endfunction

    task automatic add_sample(input logic axis, input logic [SAMPLE_W-1:0] sample,
                              input logic [2:0] gap, input logic drain);
        t_sample_req r;
        r.item.axis   = axis;
        r.item.sample = sample;
        r.gap         = gap;
        r.drain       = drain;
        sample_reqs.push_back(r);
    endtask

    // sender
    always @(posedge i_clk) begin : drive
        logic     nv;
        t_in_item ni;
        int       g;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            nv = i_valid;
            ni = i_item;
            g  = gap_left;
            if (i_valid && !o_stall) begin
                predict_frame(i_item);
                n_sent <= n_sent + 1;
                nv = 1'b0;
                g  = (sample_reqs.size() != 0) ? int'(sample_reqs[0].gap) : 0;
            end
            if (!nv) begin
                if (g != 0) begin
                    g--;
                end else if (sample_reqs.size() != 0 &&
                             (!sample_reqs[0].drain || frame_bytes_due.size() == 0)) begin
                    nv = 1'b1;
                    ni = sample_reqs[0].item;
                    void'(sample_reqs.pop_front());
                end
            end
            i_valid  <= nv;
            i_item   <= ni;
            gap_left <= g;
        end
    end

    // one long receiver hold-off once the stream is running at full rate
    always @(posedge i_clk) begin : long_hold
        if (i_rst_n) begin
            if (!hold_done && n_sent >= 45) begin
                hold_cnt  <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end else if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : monitor
        int        s;
        t_out_item exp_b;
        bit        calm;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            s = stall_left;
            if (o_valid && !i_stall) begin
                if (frame_bytes_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: unexpected frame byte %h last %b",
                                 $time, o_item.frame_byte, o_item.last);
                end else begin
                    exp_b = frame_bytes_due.pop_front();
                    if (o_item.frame_byte !== exp_b.frame_byte ||
                        o_item.last !== exp_b.last) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("%0t: byte %0d: expected %h last %b, got %h last %b",
                                     $time, n_checked, exp_b.frame_byte, exp_b.last,
                                     o_item.frame_byte, o_item.last);
                    end
                end
                n_checked++;
                calm = ((n_checked / 48) % 3) == 2;
                s = calm ? 0 : int'($urandom_range(0, 7));
            end else if (s != 0) begin
                s--;
            end
            stall_left <= s;
            i_stall    <= (s != 0) || (hold_cnt > 1);
        end
    end

    initial begin : stimulus
        logic [SAMPLE_W-1:0] smp;
        logic [2:0]          gp;
        logic                dr;
        for (int a = 0; a < AXES; a++)
            for (int k = 0; k < WINDOW; k++)
                axis_hist[a][k] = 0;

        // window fill from zero, full-scale both ways, negative truncation, map edges
        for (int k = 0; k < 5; k++)
            add_sample(1'b0, 12'd4095, 3'($urandom_range(0, 7)), 1'b0);
        for (int k = 0; k < 3; k++)
            add_sample(1'b1, 12'd0, 3'd0, 1'b0);
        add_sample(1'b0, 12'd0, 3'd2, 1'b0);
        add_sample(1'b0, 12'd0, 3'd0, 1'b0);
        add_sample(1'b1, 12'd2047, 3'd1, 1'b0);
        add_sample(1'b1, 12'd2048, 3'd0, 1'b0);
        add_sample(1'b0, 12'd1, 3'd0, 1'b0);
        add_sample(1'b0, 12'd8, 3'd7, 1'b0);
        add_sample(1'b0, 12'd9, 3'd0, 1'b0);
        add_sample(1'b0, 12'd4094, 3'd3, 1'b0);
        add_sample(1'b1, 12'd4095, 3'd0, 1'b0);
        add_sample(1'b1, 12'd4095, 3'd0, 1'b0);
        add_sample(1'b1, 12'd0, 3'd5, 1'b0);
        add_sample(1'b1, 12'd1, 3'd0, 1'b0);

        for (int n = 0; n < N_RANDOM; n++) begin
            case ($urandom_range(0, 7))
                0:       smp = 12'd0;
                1:       smp = 12'd4095;
                2:       smp = 12'($urandom_range(0, 15));
                3:       smp = 12'($urandom_range(4080, 4095));
                default: smp = 12'($urandom_range(0, 4095));
            endcase
            // back-to-back around the long hold and in one later stretch
            if ((n >= 20 && n < 90) || (n >= 160 && n < 175))
                gp = 3'd0;
            else
                gp = 3'($urandom_range(0, 7));
            dr = (n == 0) || (n == 120);
            add_sample(1'($urandom_range(0, 1)), smp, gp, dr);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent != N_SAMPLES)
            @(posedge i_clk);
        while (frame_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("testbench: %0d samples (%0d with negative average), %0d frame bytes checked",
                 n_sent, n_neg_avg, n_checked);
        $display("testbench: %0d mismatches, long receiver hold-off of %0d cycles",
                 n_errors, HOLD_CYCLES);
        if (n_errors == 0 && frame_bytes_due.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
